/* hdl/rvx_pkg.sv */
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types, constants and helpers of the RV32I-subset execute step.
// ----------------------------------------------------------------------------
package rvx_pkg;

    // Storage sizes
    localparam int MEM_WORDS = 4096;
    localparam int REG_COUNT = 32;
    localparam int RF_AW     = $clog2(REG_COUNT);
    localparam int DMEM_AW   = $clog2(MEM_WORDS);

    // Field widths
    localparam int XLEN    = 32;
    localparam int PC_W    = 16;
    localparam int MODE_W  = 5;
    localparam int IMM_W   = 12;

    // Program counter constants
    localparam logic [PC_W-1:0] RESET_PC = 16'd1000;
    localparam logic [PC_W-1:0] PC_STEP  = 16'd4;

    // Highest register index that comes out of reset holding its own index
    localparam int RF_PRESET_LAST = 6;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 5'd0,
        MODE_SUB  = 5'd1,
        MODE_ADDI = 5'd2,
        MODE_AND  = 5'd3,
        MODE_OR   = 5'd4,
        MODE_XOR  = 5'd5,
        MODE_ANDI = 5'd6,
        MODE_ORI  = 5'd7,
        MODE_XORI = 5'd8,
        MODE_SLL  = 5'd9,
        MODE_SRL  = 5'd10,
        MODE_SRA  = 5'd11,
        MODE_SLLI = 5'd12,
        MODE_SRLI = 5'd13,
        MODE_SRAI = 5'd14,
        MODE_LW   = 5'd15,
        MODE_SW   = 5'd16,
        MODE_BEQ  = 5'd17,
        MODE_BNE  = 5'd18,
        MODE_BGE  = 5'd19,
        MODE_BLT  = 5'd20,
        MODE_JAL  = 5'd21,
        MODE_JALR = 5'd22,
        MODE_EXIT = 5'd23,
        MODE_NOP  = 5'd24
    } t_mode;

    // One decoded instruction
    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [RF_AW-1:0]       reg_first;
        logic [RF_AW-1:0]       reg_second;
        logic [RF_AW-1:0]       reg_third;
        logic signed [IMM_W-1:0] immediate;
        logic [PC_W-1:0]        target_address;
    } t_instr;

    // Result of one instruction as it leaves the execute stage
    typedef struct packed {
        logic [PC_W-1:0]  next_pc;
        logic             reg_wr;
        logic [RF_AW-1:0] wr_idx;
        logic [XLEN-1:0]  wr_val;
        logic             taken;
        logic             exited;
        logic             fault;
        logic             load;     // wr_val comes from the data memory
    } t_result;

    // Data memory request issued by the execute stage
    typedef struct packed {
        logic               rd;
        logic               wr;
        logic [DMEM_AW-1:0] idx;
        logic [XLEN-1:0]    data;
    } t_mem_req;

    // Register write-back forwarding source
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] idx;
        logic [XLEN-1:0]  val;
    } t_fwd;

    // Second read port serves rt for register-register ops, else reg_first
    function automatic logic is_rtype(input logic [MODE_W-1:0] mode);
        logic r;
        case (t_mode'(mode))
            MODE_ADD, MODE_SUB, MODE_AND, MODE_OR, MODE_XOR,
            MODE_SLL, MODE_SRL, MODE_SRA: r = 1'b1;
            default:                      r = 1'b0;
        endcase
        return r;
    endfunction

    // Register value after reset
    function automatic logic [XLEN-1:0] rf_reset_val(input logic [RF_AW-1:0] idx);
        logic [XLEN-1:0] v;
        if (idx <= RF_AW'(RF_PRESET_LAST)) begin
            v = XLEN'(idx);
        end else begin
            v = '0;
        end
        return v;
    endfunction

endpackage

/* hdl/rv32i_subset_execute_step.sv */
// ----------------------------------------------------------------------------
// rv32i_subset_execute_step
// Executes one decoded RV32I-subset instruction per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one decoded instruction per
//   item; output channel (o_valid / i_ready) returns one result per item.
//   i_cfg_wr_en / i_cfg_wr_data write start_pc and load the program counter;
//   write only while no item is in flight.
//   An accepted item is held in the operand stage register (the register
//   file is read at the accepting edge), and execute then fills the result
//   register. One item per cycle while the receiver takes results, with
//   back-to-back dependent instructions handled by forwarding from the result
//   and write-back registers; the load data path runs through the data memory
//   read port.
//   Reset: registers x1..x6 read their index, all others zero, PC = 1000.
//   After reset the data memory is cleared one word per cycle, all MEM_WORDS
//   (4096) words, with o_ready low; configuration writes are taken as ever.
//   A stalled receiver holds the result register; the item behind it waits
//   in the execute stage and o_ready drops once both stages are full.
// ----------------------------------------------------------------------------
module rv32i_subset_execute_step
    import rvx_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration
    input  logic                    i_cfg_wr_en,
    input  logic [PC_W-1:0]         i_cfg_wr_data,
    // Instruction channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [RF_AW-1:0]        i_reg_first,
    input  logic [RF_AW-1:0]        i_reg_second,
    input  logic [RF_AW-1:0]        i_reg_third,
    input  logic signed [IMM_W-1:0] i_immediate,
    input  logic [PC_W-1:0]         i_target_address,
    // Result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [PC_W-1:0]         o_next_pc,
    output logic                    o_reg_written,
    output logic [RF_AW-1:0]        o_written_index,
    output logic signed [XLEN-1:0]  o_written_value,
    output logic                    o_branch_taken,
    output logic                    o_exited,
    output logic                    o_address_fault
);

    logic               accept;
    logic               s1_adv;
    logic               drain;

    logic               r_s1_valid;
    t_instr             r_s1;
    logic [RF_AW-1:0]   r_s1_bidx;
    logic               r_s2_valid;
    t_result            r_s2;
    t_fwd               r_wb;
    logic [PC_W-1:0]    r_pc;
    logic               r_clr_busy;
    logic [DMEM_AW-1:0] r_clr_addr;

    logic [RF_AW-1:0]   rd_bidx;
    logic [XLEN-1:0]    rf_a;
    logic [XLEN-1:0]    rf_b;
    logic [XLEN-1:0]    op_a;
    logic [XLEN-1:0]    op_b;
    logic [XLEN-1:0]    dmem_rdata;
    logic [XLEN-1:0]    s2_val;
    t_result            ex_res;
    t_mem_req           ex_mem;

    logic               dm_wr_en;
    logic [DMEM_AW-1:0] dm_wr_addr;
    logic [XLEN-1:0]    dm_wr_data;

    // Handshake
    assign drain   = r_s2_valid && i_ready;
    assign s1_adv  = r_s1_valid && (!r_s2_valid || i_ready);
    assign o_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign accept  = i_valid && o_ready;

    // Pick the second read register at issue
    assign rd_bidx = is_rtype(i_mode) ? i_reg_third : i_reg_first;

    // Operand stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.mode           <= i_mode;
            r_s1.reg_first      <= i_reg_first;
            r_s1.reg_second     <= i_reg_second;
            r_s1.reg_third      <= i_reg_third;
            r_s1.immediate      <= i_immediate;
            r_s1.target_address <= i_target_address;
            r_s1_bidx           <= rd_bidx;
        end
    end

    rvx_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (i_reg_second),
        .i_rd_addr_b (rd_bidx),
        .i_wr_en     (drain && r_s2.reg_wr),
        .i_wr_addr   (r_s2.wr_idx),
        .i_wr_data   (s2_val),
        .o_rd_data_a (rf_a),
        .o_rd_data_b (rf_b)
    );

    // Result value of the item in the result register
    assign s2_val = r_s2.load ? dmem_rdata : r_s2.wr_val;

    // Forward from the result register, then from the last write-back
    always_comb begin
        if (r_s2_valid && r_s2.reg_wr && (r_s2.wr_idx == r_s1.reg_second)) begin
            op_a = s2_val;
        end else if (r_wb.en && (r_wb.idx == r_s1.reg_second)) begin
            op_a = r_wb.val;
        end else begin
            op_a = rf_a;
        end
        if (r_s2_valid && r_s2.reg_wr && (r_s2.wr_idx == r_s1_bidx)) begin
            op_b = s2_val;
        end else if (r_wb.en && (r_wb.idx == r_s1_bidx)) begin
            op_b = r_wb.val;
        end else begin
            op_b = rf_b;
        end
    end

    rvx_exec u_exec (
        .i_instr (r_s1),
        .i_pc    (r_pc),
        .i_op_a  (op_a),
        .i_op_b  (op_b),
        .o_res   (ex_res),
        .o_mem   (ex_mem)
    );

    // Capture the last register write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb.en <= 1'b0;
        end else if (drain && r_s2.reg_wr) begin
            r_wb.en <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain && r_s2.reg_wr) begin
            r_wb.idx <= r_s2.wr_idx;
            r_wb.val <= s2_val;
        end
    end

    // Program counter: configuration load or commit from the execute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= RESET_PC;
        end else if (i_cfg_wr_en) begin
            r_pc <= i_cfg_wr_data;
        end else if (s1_adv) begin
            r_pc <= ex_res.next_pc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (drain) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2 <= ex_res;
        end
    end

    // Clear the data memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == DMEM_AW'(MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Data memory port: clearing pass or store from the execute stage
    assign dm_wr_en   = r_clr_busy || (s1_adv && ex_mem.wr);
    assign dm_wr_addr = r_clr_busy ? r_clr_addr : ex_mem.idx;
    assign dm_wr_data = r_clr_busy ? '0 : ex_mem.data;

    rvx_ram #(.P_WIDTH(XLEN), .P_DEPTH(MEM_WORDS)) u_dmem (
        .i_clk     (i_clk),
        .i_wr_en   (dm_wr_en),
        .i_wr_addr (dm_wr_addr),
        .i_wr_data (dm_wr_data),
        .i_rd_en   (s1_adv && ex_mem.rd),
        .i_rd_addr (ex_mem.idx),
        .o_rd_data (dmem_rdata)
    );

    // Output drive
    assign o_valid         = r_s2_valid;
    assign o_next_pc       = r_s2.next_pc;
    assign o_reg_written   = r_s2.reg_wr;
    assign o_written_index = r_s2.wr_idx;
    assign o_written_value = s2_val;
    assign o_branch_taken  = r_s2.taken;
    assign o_exited        = r_s2.exited;
    assign o_address_fault = r_s2.fault;

    // Checks
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready)
        else $error("item accepted during data memory clear");

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reg_written) |-> (o_written_index != '0))
        else $error("write to x0 reported");

    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reg_written) |-> (o_written_index == '0 && o_written_value == '0))
        else $error("non-writing result carries index or value");

    a_exit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_exited) |-> (!o_reg_written && !o_branch_taken && !o_address_fault))
        else $error("exit result has side effects");

    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_address_fault) |-> (!o_reg_written && !o_branch_taken))
        else $error("faulted access wrote a register or branched");

endmodule

/* hdl/rvx_ram.sv */
// ----------------------------------------------------------------------------
// rvx_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module rvx_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/rvx_regfile.sv */
// ----------------------------------------------------------------------------
// rvx_regfile
// Register file with two read ports: two RAM copies written together, plus
// one valid bit per register so that unwritten entries read as reset values.
// ----------------------------------------------------------------------------
module rvx_regfile
    import rvx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [RF_AW-1:0] i_rd_addr_a,
    input  logic [RF_AW-1:0] i_rd_addr_b,
    input  logic             i_wr_en,
    input  logic [RF_AW-1:0] i_wr_addr,
    input  logic [XLEN-1:0]  i_wr_data,
    output logic [XLEN-1:0]  o_rd_data_a,
    output logic [XLEN-1:0]  o_rd_data_b
);

    logic [REG_COUNT-1:0] r_vld;
    logic [RF_AW-1:0]     r_addr_a;
    logic [RF_AW-1:0]     r_addr_b;
    logic [XLEN-1:0]      ram_a;
    logic [XLEN-1:0]      ram_b;

    rvx_ram #(.P_WIDTH(XLEN), .P_DEPTH(REG_COUNT)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr_a),
        .o_rd_data (ram_a)
    );

    rvx_ram #(.P_WIDTH(XLEN), .P_DEPTH(REG_COUNT)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr_b),
        .o_rd_data (ram_b)
    );

    // Mark written registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Hold read addresses alongside the RAM read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_addr_a <= i_rd_addr_a;
            r_addr_b <= i_rd_addr_b;
        end
    end

    // Substitute reset values for never-written entries
    assign o_rd_data_a = r_vld[r_addr_a] ? ram_a : rf_reset_val(r_addr_a);
    assign o_rd_data_b = r_vld[r_addr_b] ? ram_b : rf_reset_val(r_addr_b);

endmodule

/* hdl/rvx_exec.sv */
// ----------------------------------------------------------------------------
// rvx_exec
// Execute logic: ALU, branch compare, jump targets, memory address check.
// Purely combinational; sits between the operand stage and result register.
// ----------------------------------------------------------------------------
module rvx_exec
    import rvx_pkg::*;
(
    input  t_instr          i_instr,
    input  logic [PC_W-1:0] i_pc,
    input  logic [XLEN-1:0] i_op_a,   // register at reg_second
    input  logic [XLEN-1:0] i_op_b,   // reg_third for R-type, else reg_first
    output t_result         o_res,
    output t_mem_req        o_mem
);

    logic [XLEN-1:0]        imm32;
    logic [PC_W-1:0]        seq_pc;
    logic signed [XLEN:0]   addr_sum;
    logic                   addr_ok;
    logic                   lt;
    logic [XLEN-1:0]        jalr_sum;
    logic                   wr;
    logic [XLEN-1:0]        val;

    // Operand preparation
    assign imm32    = {{(XLEN-IMM_W){i_instr.immediate[IMM_W-1]}}, i_instr.immediate};
    assign seq_pc   = i_pc + PC_STEP;
    assign addr_sum = $signed({i_op_a[XLEN-1], i_op_a}) + $signed({imm32[XLEN-1], imm32});
    assign addr_ok  = !addr_sum[XLEN] && (addr_sum[XLEN-1:0] < XLEN'(MEM_WORDS));
    assign lt       = $signed(i_op_b) < $signed(i_op_a);
    assign jalr_sum = i_op_a + imm32;

    // Decode and compute
    always_comb begin
        o_res        = '0;
        o_res.next_pc = seq_pc;
        wr           = 1'b0;
        val          = '0;
        o_mem        = '0;
        o_mem.idx    = addr_sum[DMEM_AW-1:0];
        o_mem.data   = i_op_b;
        case (t_mode'(i_instr.mode))
            MODE_ADD:  begin val = i_op_a + i_op_b; wr = 1'b1; end
            MODE_SUB:  begin val = i_op_a - i_op_b; wr = 1'b1; end
            MODE_ADDI: begin val = i_op_a + imm32;  wr = 1'b1; end
            MODE_AND:  begin val = i_op_a & i_op_b; wr = 1'b1; end
            MODE_OR:   begin val = i_op_a | i_op_b; wr = 1'b1; end
            MODE_XOR:  begin val = i_op_a ^ i_op_b; wr = 1'b1; end
            MODE_ANDI: begin val = i_op_a & imm32;  wr = 1'b1; end
            MODE_ORI:  begin val = i_op_a | imm32;  wr = 1'b1; end
            MODE_XORI: begin val = i_op_a ^ imm32;  wr = 1'b1; end
            MODE_SLL:  begin val = i_op_a << i_op_b[4:0]; wr = 1'b1; end
            MODE_SRL:  begin val = i_op_a >> i_op_b[4:0]; wr = 1'b1; end
            MODE_SRA:  begin
                val = XLEN'($signed(i_op_a) >>> i_op_b[4:0]);
                wr  = 1'b1;
            end
            MODE_SLLI: begin val = i_op_a << imm32[4:0]; wr = 1'b1; end
            MODE_SRLI: begin val = i_op_a >> imm32[4:0]; wr = 1'b1; end
            MODE_SRAI: begin
                val = XLEN'($signed(i_op_a) >>> imm32[4:0]);
                wr  = 1'b1;
            end
            MODE_LW: begin
                // Data arrives from memory one stage later
                o_mem.rd    = addr_ok;
                o_res.fault = !addr_ok;
                o_res.load  = addr_ok && (i_instr.reg_first != '0);
                wr          = addr_ok;
            end
            MODE_SW: begin
                o_mem.wr    = addr_ok;
                o_res.fault = !addr_ok;
            end
            MODE_BEQ, MODE_BNE, MODE_BGE, MODE_BLT: begin
                case (t_mode'(i_instr.mode))
                    MODE_BEQ: o_res.taken = (i_op_b == i_op_a);
                    MODE_BNE: o_res.taken = (i_op_b != i_op_a);
                    MODE_BGE: o_res.taken = !lt;
                    default:  o_res.taken = lt;
                endcase
                if (o_res.taken) begin
                    o_res.next_pc = i_instr.target_address;
                end
            end
            MODE_JAL: begin
                val           = XLEN'(seq_pc);
                wr            = 1'b1;
                o_res.next_pc = i_instr.target_address;
                o_res.taken   = 1'b1;
            end
            MODE_JALR: begin
                val           = XLEN'(seq_pc);
                wr            = 1'b1;
                o_res.next_pc = {jalr_sum[PC_W-1:1], 1'b0};
                o_res.taken   = 1'b1;
            end
            MODE_EXIT: begin
                o_res.exited  = 1'b1;
                o_res.next_pc = i_pc;
            end
            default: begin
                // Label no-op and unused codes
                o_res.next_pc = i_pc;
            end
        endcase
        // Drop writes to x0
        if (wr && (i_instr.reg_first != '0)) begin
            o_res.reg_wr = 1'b1;
            o_res.wr_idx = i_instr.reg_first;
            o_res.wr_val = o_res.load ? '0 : val;
        end
    end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RV32I-subset execute step. A queue of decoded
// instructions feeds a bursty driver; a monitor predicts each accepted item
// from its own copy of registers, data memory and PC and checks every result
// field against that prediction while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top
    import rvx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_LAST = (1 << MODE_W) - 1;  // top of the unused mode range
    localparam int IMM_MAX   = (1 << (IMM_W - 1)) - 1;
    localparam int ERR_SHOWN = 20;

    // Expected outcome of one instruction
    typedef struct packed {
        logic [PC_W-1:0]  next_pc;
        logic             reg_wr;
        logic [RF_AW-1:0] idx;
        logic [XLEN-1:0]  val;
        logic             taken;
        logic             exited;
        logic             fault;
    } t_outcome;

    // Block ports
    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_cfg_wr_en      = 1'b0;
    logic [PC_W-1:0]         i_cfg_wr_data    = '0;
    logic                    i_valid          = 1'b0;
    logic                    o_ready;
    logic [MODE_W-1:0]       i_mode           = '0;
    logic [RF_AW-1:0]        i_reg_first      = '0;
    logic [RF_AW-1:0]        i_reg_second     = '0;
    logic [RF_AW-1:0]        i_reg_third      = '0;
    logic signed [IMM_W-1:0] i_immediate      = '0;
    logic [PC_W-1:0]         i_target_address = '0;
    logic                    o_valid;
    logic                    i_ready          = 1'b1;
    logic [PC_W-1:0]         o_next_pc;
    logic                    o_reg_written;
    logic [RF_AW-1:0]        o_written_index;
    logic signed [XLEN-1:0]  o_written_value;
    logic                    o_branch_taken;
    logic                    o_exited;
    logic                    o_address_fault;

    // Predicted architectural state
    logic [XLEN-1:0] arch_regs [REG_COUNT];
    logic [XLEN-1:0] data_words [MEM_WORDS];
    logic [PC_W-1:0] arch_pc;
    logic [PC_W-1:0] start_pc_q;

    // Instruction and outcome stores, progress counters
    t_instr   pending_instrs[$];
    t_outcome expected_results[$];
    int       n_queued   = 0;
    int       n_accepted = 0;
    int       n_results  = 0;
    int       n_err      = 0;
    int       n_cfg      = 0;
    int       n_reg_wr   = 0;
    int       n_taken    = 0;
    int       n_fault    = 0;
    int       n_exit     = 0;
    logic     in_fire    = 1'b0;

    // Idling controls
    int   burst_left = 1;
    int   gap_left   = 0;
    int   rx_left    = 0;
    logic tx_steady  = 1'b0;
    logic rx_steady  = 1'b0;

    rv32i_subset_execute_step i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_reg_first      (i_reg_first),
        .i_reg_second     (i_reg_second),
        .i_reg_third      (i_reg_third),
        .i_immediate      (i_immediate),
        .i_target_address (i_target_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_next_pc        (o_next_pc),
        .o_reg_written    (o_reg_written),
        .o_written_index  (o_written_index),
        .o_written_value  (o_written_value),
        .o_branch_taken   (o_branch_taken),
        .o_exited         (o_exited),
        .o_address_fault  (o_address_fault)
    );

    always #5 i_clk = ~i_clk;

    // Print one mismatch line (up to a cap) and count it
    task automatic report_mismatch(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
        n_err++;
        if (n_err <= ERR_SHOWN) begin
            $display("mismatch in %s at result %0d: got %h, want %h", what, n_results, got, want);
        end
    endtask

    // Restore the predicted state to its reset contents
    function automatic void reset_arch_state();
        for (int i = 0; i < REG_COUNT; i++) begin
            arch_regs[i] = (i <= RF_PRESET_LAST) ? XLEN'(i) : '0;
        end
        for (int i = 0; i < MEM_WORDS; i++) begin
            data_words[i] = '0;
        end
        start_pc_q = RESET_PC;
        arch_pc    = RESET_PC;
    endfunction

    // Execute one instruction on the predicted state and return its outcome
    function automatic t_outcome execute_instr(t_instr ins);
        t_outcome        r;
        logic [XLEN-1:0] a, b, c, imm, val;
        logic [PC_W-1:0] seq, nxt;
        logic            wr;
        longint          addr;
        a    = arch_regs[ins.reg_second];
        b    = arch_regs[ins.reg_third];
        c    = arch_regs[ins.reg_first];
        imm  = {{(XLEN-IMM_W){ins.immediate[IMM_W-1]}}, ins.immediate};
        seq  = arch_pc + PC_STEP;
        nxt  = seq;
        val  = '0;
        wr   = 1'b1;
        r    = '0;
        addr = longint'($signed(a)) + longint'($signed(imm));
        case (ins.mode)
            MODE_ADD:  val = a + b;
            MODE_SUB:  val = a - b;
            MODE_ADDI: val = a + imm;
            MODE_AND:  val = a & b;
            MODE_OR:   val = a | b;
            MODE_XOR:  val = a ^ b;
            MODE_ANDI: val = a & imm;
            MODE_ORI:  val = a | imm;
            MODE_XORI: val = a ^ imm;
            MODE_SLL:  val = a << b[4:0];
            MODE_SRL:  val = a >> b[4:0];
            MODE_SRA:  val = $signed(a) >>> b[4:0];
            MODE_SLLI: val = a << imm[4:0];
            MODE_SRLI: val = a >> imm[4:0];
            MODE_SRAI: val = $signed(a) >>> imm[4:0];
            MODE_LW, MODE_SW: begin
                // out-of-range word address: no access at all
                wr = 1'b0;
                if (addr < 0 || addr >= MEM_WORDS) begin
                    r.fault = 1'b1;
                end else if (ins.mode == MODE_LW) begin
                    val = data_words[int'(addr)];
                    wr  = 1'b1;
                end else begin
                    data_words[int'(addr)] = c;
                end
            end
            MODE_BEQ, MODE_BNE, MODE_BGE, MODE_BLT: begin
                wr = 1'b0;
                case (ins.mode)
                    MODE_BEQ: r.taken = (c == a);
                    MODE_BNE: r.taken = (c != a);
                    MODE_BGE: r.taken = ($signed(c) >= $signed(a));
                    default:  r.taken = ($signed(c) < $signed(a));
                endcase
                if (r.taken) begin
                    nxt = ins.target_address;
                end
            end
            MODE_JAL: begin
                val     = XLEN'(seq);
                nxt     = ins.target_address;
                r.taken = 1'b1;
            end
            MODE_JALR: begin
                // target from the base value read before the link write
                val     = XLEN'(seq);
                nxt     = PC_W'((a + imm) & ~XLEN'(1));
                r.taken = 1'b1;
            end
            MODE_EXIT: begin
                wr       = 1'b0;
                r.exited = 1'b1;
                nxt      = arch_pc;
            end
            default: begin
                // label no-op and unused modes hold the PC
                wr  = 1'b0;
                nxt = arch_pc;
            end
        endcase
        if (wr && ins.reg_first != '0) begin
            arch_regs[ins.reg_first] = val;
            r.reg_wr = 1'b1;
            r.idx    = ins.reg_first;
            r.val    = val;
        end
        arch_pc   = nxt;
        r.next_pc = nxt;
        return r;
    endfunction

    // Compare one result with the oldest expectation
    task automatic check_result();
        t_outcome want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no instruction pending", XLEN'(o_next_pc), '0);
        end else begin
            want = expected_results.pop_front();
            if (o_next_pc !== want.next_pc)
                report_mismatch("next_pc", XLEN'(o_next_pc), XLEN'(want.next_pc));
            if (o_reg_written !== want.reg_wr)
                report_mismatch("reg_written", XLEN'(o_reg_written), XLEN'(want.reg_wr));
            if (o_written_index !== want.idx)
                report_mismatch("written_index", XLEN'(o_written_index), XLEN'(want.idx));
            if (o_written_value !== want.val)
                report_mismatch("written_value", o_written_value, want.val);
            if (o_branch_taken !== want.taken)
                report_mismatch("branch_taken", XLEN'(o_branch_taken), XLEN'(want.taken));
            if (o_exited !== want.exited)
                report_mismatch("exited", XLEN'(o_exited), XLEN'(want.exited));
            if (o_address_fault !== want.fault)
                report_mismatch("address_fault", XLEN'(o_address_fault), XLEN'(want.fault));
        end
    endtask

    // Monitor: predict on accepted items, check delivered results
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = execute_instr('{mode: i_mode, reg_first: i_reg_first,
                                       reg_second: i_reg_second, reg_third: i_reg_third,
                                       immediate: i_immediate,
                                       target_address: i_target_address});
                expected_results.push_back(want);
                n_reg_wr   += int'(want.reg_wr);
                n_taken    += int'(want.taken);
                n_fault    += int'(want.fault);
                n_exit     += int'(want.exited);
                n_accepted <= n_accepted + 1;
            end
            if (o_valid && i_ready) begin
                check_result();
                n_results <= n_results + 1;
            end
        end
        in_fire <= i_rst_n && i_valid && o_ready;
    end

    // Driver: hold until accepted, otherwise send in bursts with gaps
    always @(negedge i_clk) begin : driver
        t_instr nxt_instr;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_fire) begin
            // hold the current item
        end else if (gap_left != 0) begin
            i_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_instrs.size() != 0) begin
            nxt_instr        = pending_instrs.pop_front();
            i_mode           <= nxt_instr.mode;
            i_reg_first      <= nxt_instr.reg_first;
            i_reg_second     <= nxt_instr.reg_second;
            i_reg_third      <= nxt_instr.reg_third;
            i_immediate      <= nxt_instr.immediate;
            i_target_address <= nxt_instr.target_address;
            i_valid          <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 16);
                gap_left   <= tx_steady ? 0 : $urandom_range(1, 5);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver: alternate ready runs and stalls of random length
    always @(negedge i_clk) begin
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (rx_steady || !i_ready) begin
            i_ready <= 1'b1;
            rx_left <= $urandom_range(1, 20);
        end else begin
            i_ready <= 1'b0;
            rx_left <= $urandom_range(0, 6);
        end
    end

    // Queue one instruction for the driver
    task automatic push_instr(t_instr ins);
        pending_instrs.push_back(ins);
        n_queued++;
    endtask

    task automatic queue_instr(logic [MODE_W-1:0] mode, logic [RF_AW-1:0] first,
                               logic [RF_AW-1:0] second, logic [RF_AW-1:0] third,
                               int imm, int tgt);
        t_instr ins;
        ins.mode           = mode;
        ins.reg_first      = first;
        ins.reg_second     = second;
        ins.reg_third      = third;
        ins.immediate      = IMM_W'(imm);
        ins.target_address = PC_W'(tgt);
        push_instr(ins);
    endtask

    // Favor a few low registers so results feed later operands
    function automatic logic [RF_AW-1:0] pick_reg();
        return ($urandom_range(0, 1) != 0) ? RF_AW'($urandom_range(0, REG_COUNT - 1))
                                           : RF_AW'($urandom_range(0, 7));
    endfunction

    function automatic t_instr random_instr();
        t_instr ins;
        int     sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            ins.mode = MODE_W'($urandom_range(MODE_ADD, MODE_SRAI));
        else if (sel < 60)
            ins.mode = ($urandom_range(0, 1) != 0) ? MODE_LW : MODE_SW;
        else if (sel < 78)
            ins.mode = MODE_W'($urandom_range(MODE_BEQ, MODE_BLT));
        else if (sel < 88)
            ins.mode = ($urandom_range(0, 1) != 0) ? MODE_JAL : MODE_JALR;
        else if (sel < 95)
            ins.mode = ($urandom_range(0, 1) != 0) ? MODE_EXIT : MODE_NOP;
        else
            ins.mode = MODE_W'($urandom_range(MODE_NOP + 1, MODE_LAST));
        ins.reg_first      = pick_reg();
        ins.reg_second     = pick_reg();
        ins.reg_third      = pick_reg();
        ins.immediate      = IMM_W'($urandom_range(0, (1 << IMM_W) - 1));
        ins.target_address = PC_W'($urandom_range(0, (1 << PC_W) - 1));
        return ins;
    endfunction

    // Set up a base register, store a few words, then load them back
    task automatic queue_mem_sequence();
        logic [RF_AW-1:0] base_reg, dest;
        int               base, lo, hi, n, step;
        int               offs [4];
        base_reg = RF_AW'($urandom_range(1, REG_COUNT - 1));
        base     = $urandom_range(0, IMM_MAX);
        queue_instr(MODE_ADDI, base_reg, 0, pick_reg(), base, $urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0) begin
            step = $urandom_range(0, IMM_MAX);
            queue_instr(MODE_ADDI, base_reg, base_reg, pick_reg(), step, 0);
            base += step;
        end
        lo = (base - IMM_MAX - 1 < 0) ? 0 : base - IMM_MAX - 1;
        hi = (base + IMM_MAX > MEM_WORDS - 1) ? MEM_WORDS - 1 : base + IMM_MAX;
        n  = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            offs[i] = int'($urandom_range(lo, hi)) - base;
            // now and then step just past either end of the memory
            if ($urandom_range(0, 7) == 0) begin
                if (base <= IMM_MAX)
                    offs[i] = -base - 1;
                else if (base > IMM_MAX + 1)
                    offs[i] = MEM_WORDS - base;
            end
            queue_instr(MODE_SW, pick_reg(), base_reg, pick_reg(), offs[i],
                        $urandom_range(0, 65535));
        end
        for (int i = 0; i < n; i++) begin
            dest = pick_reg();
            if (dest == base_reg) dest = '0;
            queue_instr(MODE_LW, dest, base_reg, pick_reg(), offs[i], $urandom_range(0, 65535));
        end
    endtask

    // Wait until every queued item has been accepted
    task automatic wait_sent();
        do @(posedge i_clk); while (n_accepted != n_queued);
    endtask

    // Wait until every queued item has been accepted and answered
    task automatic wait_drained();
        do @(posedge i_clk); while (n_accepted != n_queued || n_results < n_accepted);
    endtask

    // Write start_pc; the block is idle, so the model follows at once
    task automatic write_start_pc(logic [PC_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        start_pc_q = value;
        arch_pc    = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        n_cfg++;
    endtask

    task automatic run_random_phase(int count);
        int stop_at, chunk_end;
        stop_at = n_queued + count;
        while (n_queued < stop_at) begin
            @(posedge i_clk);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            chunk_end = n_queued + $urandom_range(20, 80);
            while (n_queued < chunk_end && n_queued < stop_at) begin
                if ($urandom_range(0, 3) == 0)
                    queue_mem_sequence();
                else
                    push_instr(random_instr());
            end
            // sometimes pause the sender until every result is back
            if ($urandom_range(0, 2) == 0)
                wait_drained();
            else
                wait_sent();
        end
        wait_drained();
    endtask

    // Run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus sequence
    initial begin
        reset_arch_state();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // start just below the wrap point; the memory clear is still running
        write_start_pc(PC_W'(16'hFFFC));

        // Directed: extremes, every operation, special cases
        @(posedge i_clk);
        queue_instr(MODE_ADDI, 7, 0, 0, -1, 0);
        queue_instr(MODE_SRLI, 8, 7, 0, 1, 0);
        queue_instr(MODE_SLLI, 9, 7, 0, -1, 0);            // shift by low 5 bits only
        queue_instr(MODE_SUB, 13, 9, 1, 0, 0);             // wraps past the most negative
        queue_instr(MODE_ADD, 0, 8, 1, 0, 0);              // x0 destination is dropped
        queue_instr(MODE_SRA, 15, 9, 3, 0, 0);
        queue_instr(MODE_SRL, 16, 9, 3, 0, 0);
        queue_instr(MODE_SRAI, 17, 9, 0, -2017, 0);
        queue_instr(MODE_SLL, 18, 1, 7, 0, 0);
        queue_instr(MODE_AND, 19, 8, 7, 0, 0);
        queue_instr(MODE_OR, 20, 8, 9, 0, 0);
        queue_instr(MODE_XOR, 21, 7, 8, 0, 0);
        queue_instr(MODE_ANDI, 22, 7, 0, -IMM_MAX - 1, 0);
        queue_instr(MODE_ORI, 12, 0, 0, IMM_MAX, 0);
        queue_instr(MODE_XORI, 23, 7, 0, -1, 0);
        queue_instr(MODE_ADDI, 24, 0, 0, IMM_MAX, 0);
        queue_instr(MODE_ADDI, 24, 24, 0, IMM_MAX, 0);
        queue_instr(MODE_SW, 9, 24, 0, 1, 0);              // last word of memory
        queue_instr(MODE_LW, 25, 24, 0, 1, 0);
        queue_instr(MODE_LW, 26, 24, 0, 2, 0);             // one past the end
        queue_instr(MODE_SW, 1, 0, 0, -1, 0);              // below zero
        queue_instr(MODE_BEQ, 1, 1, 0, 0, 16'hFFFF);
        queue_instr(MODE_BNE, 1, 1, 0, 0, 16'h1234);
        queue_instr(MODE_BLT, 9, 8, 0, 0, 0);
        queue_instr(MODE_BGE, 9, 8, 0, 0, 16'h00F0);
        queue_instr(MODE_JAL, 28, 0, 0, 0, 16'hFFFE);
        queue_instr(MODE_JALR, 5, 5, 0, 3, 0);             // base equals link register
        queue_instr(MODE_EXIT, 0, 0, 0, 0, 0);
        queue_instr(MODE_NOP, 0, 0, 0, 0, 0);
        queue_instr(MODE_W'(MODE_LAST), 1, 2, 3, 0, 0);
        wait_drained();

        // Random phases under different start addresses
        write_start_pc('0);
        run_random_phase(260);
        write_start_pc('1);
        run_random_phase(260);
        write_start_pc(PC_W'($urandom_range(0, 65535)));
        run_random_phase(260);
        write_start_pc(RESET_PC);
        run_random_phase(260);

        // Let any stray result surface before closing
        repeat (4) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch("results never delivered", XLEN'(expected_results.size()), '0);
        end

        $display("covered %0d instructions under %0d start_pc settings, %0d register writes",
                 n_accepted, n_cfg, n_reg_wr);
        $display("covered %0d taken branches or jumps, %0d address faults, %0d exits",
                 n_taken, n_fault, n_exit);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/rvx_pkg.sv
hdl/rvx_ram.sv
hdl/rvx_regfile.sv
hdl/rvx_exec.sv
hdl/rv32i_subset_execute_step.sv
verif/tb_top.sv
